/* sv/min_heap_priority_queue_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the min-heap priority queue unit
// Clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MIN_HEAP_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define MIN_HEAP_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MHPQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MHPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/mhpq_pkg.sv */
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared sizes, types and helpers of the min-heap priority queue unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mhpq_pkg;

  // Heap size and field widths.
  localparam int CAPACITY = 256;
  localparam int KEY_BITS = 32;
  localparam int VTX_W    = 8;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = SLOT_W + 1;
  localparam int SLOTX_W  = SLOT_W + 2;

  // Heap levels: one level cell per level of the tree.
  localparam int NLEV  = SLOT_W + 1;
  localparam int LVL_W = $clog2(NLEV);
  localparam int POS_W = SLOT_W;

  // Each memory row of a level holds a pair of siblings.
  localparam int ROW_W = SLOT_W - 2;
  localparam int ROWS  = 2 ** ROW_W;

  // Vertex search scans the match vector one chunk per cycle.
  localparam int CHUNK_W = 4;
  localparam int CHUNK   = 2 ** CHUNK_W;
  localparam int CIDX_W  = SLOT_W - CHUNK_W;

  typedef struct packed {
    logic signed [KEY_BITS-1:0] key;
    logic [VTX_W-1:0]           vtx;
  } entry_t;

  // Sibling pair of one memory row; lo holds the even position.
  typedef struct packed {
    entry_t hi;
    entry_t lo;
  } pair_t;

  // Request broadcast to all level cells.
  typedef struct packed {
    logic [ROW_W-1:0] rd_row;
    logic [ROW_W-1:0] wr_row;
    logic             wr_lo;
    logic             wr_hi;
    entry_t           wr_ent;
  } cell_req_t;

  // Location of a heap slot: level and position within the level.
  typedef struct packed {
    logic [LVL_W-1:0] lvl;
    logic [POS_W-1:0] pos;
  } loc_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [VTX_W-1:0]  vtx;
  } match_wr_t;

  typedef struct packed {
    logic              done;
    logic              found;
    logic [SLOT_W-1:0] slot;
  } match_res_t;

  // Signed compare of two keys.
  function automatic logic key_less(input logic signed [KEY_BITS-1:0] a,
                                    input logic signed [KEY_BITS-1:0] b);
    return a < b;
  endfunction

  // Location of the slot whose index plus one is s1 (s1 is nonzero).
  function automatic loc_t loc_of(input logic [CNT_W-1:0] s1);
    loc_t             l;
    logic [CNT_W-1:0] rest;
    l.lvl = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (s1[i]) begin
        l.lvl = LVL_W'(i);
      end
    end
    rest  = s1 & ~(CNT_W'(1) << l.lvl);
    l.pos = rest[POS_W-1:0];
    return l;
  endfunction

  // Slot index of a level and position, wide enough for child slots.
  function automatic logic [SLOTX_W-1:0] slot_of(input logic [LVL_W-1:0] lvl,
                                                 input logic [POS_W-1:0] pos);
    return (SLOTX_W'(1) << lvl) - SLOTX_W'(1) + SLOTX_W'(pos);
  endfunction

endpackage

`default_nettype wire

/* sv/min_heap_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// min_heap_priority_queue_unit
// Indexed binary min-heap of (key, vertex) pairs with insert, extract-minimum
// and decrease-key. The tree is held as a chain of level cells.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake              | Fields
//  ---------+-----------+------------------------+-----------------------------
//  in_      | input     | start high, busy low   | opcode, key, vertex
//  out_     | output    | out_valid, one cycle   | status, min_vertex,
//           |           |                        | min_key, entry_count
//
//  After acceptance, errors, no-op and an extract that empties the heap go
//  straight to the result strobe. Each level moved is a pair read, then a
//  compare and write. Decrease first scans the vertex tags a 16-slot chunk at
//  a time, then reports absence, or reads the entry and either reports it not
//  smaller or climbs like an insert. The longest request is a decrease.
//  Synchronous active-low reset empties the heap at once; no clearing pass.
//  busy stays high from acceptance through the result strobe, and results
//  cannot be held off by the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

`include "min_heap_priority_queue_unit_assert.svh"

module min_heap_priority_queue_unit import mhpq_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_opcode,
  input  logic signed [KEY_BITS-1:0] in_key,
  input  logic [VTX_W-1:0]           in_vertex,
  output logic                       out_valid,
  output logic [2:0]                 out_status,
  output logic [VTX_W-1:0]           out_min_vertex,
  output logic signed [KEY_BITS-1:0] out_min_key,
  output logic [CNT_W-1:0]           out_entry_count
);

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_EXTRACT  = 2'd1,
    OP_DECREASE = 2'd2,
    OP_NOP      = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_EMPTY       = 3'd1,
    ST_FULL        = 3'd2,
    ST_NOT_SMALLER = 3'd3,
    ST_NOT_FOUND   = 3'd4
  } status_t;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_SEARCH   = 11'b00000000010,
    S_DEC_RD   = 11'b00000000100,
    S_DEC_CHK  = 11'b00000001000,
    S_UP_RD    = 11'b00000010000,
    S_UP_CHK   = 11'b00000100000,
    S_LAST_RD  = 11'b00001000000,
    S_LAST_CHK = 11'b00010000000,
    S_DOWN_RD  = 11'b00100000000,
    S_DOWN_CHK = 11'b01000000000,
    S_DONE     = 11'b10000000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  entry_t           top_r;
  entry_t           x_r, x_nxt;
  entry_t           res_r, res_nxt;
  logic             ext_r, ext_nxt;
  status_t          status_r, status_nxt;
  logic [LVL_W-1:0] lvl_r, lvl_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;

  // Memory requests of this cycle.
  logic             rd_en;
  logic [LVL_W-1:0] rd_lvl;
  logic [ROW_W-1:0] rd_row;
  logic             wr_en;
  logic [LVL_W-1:0] wr_lvl;
  logic [POS_W-1:0] wr_pos;
  entry_t           wr_ent;
  logic             cam_load;

  logic [NLEV-1:0]    sel_rd;
  logic [NLEV-1:0]    sel_wr;
  cell_req_t          creq;
  pair_t              chain [NLEV+1];
  pair_t              rd_pair;
  match_wr_t          mwr;
  match_res_t         mres;
  logic [SLOTX_W-1:0] wr_slot;

  // Neighborhood of the current position.
  logic [LVL_W-1:0]   par_lvl;
  logic [ROW_W-1:0]   par_row;
  logic               par_half;
  logic [ROW_W-1:0]   own_row;
  logic               own_half;
  logic [SLOTX_W-1:0] kid_slot;
  logic               left_ok;
  logic               right_ok;
  entry_t             par_ent;
  entry_t             own_ent;
  logic               take_l;
  logic               take_r;
  logic signed [KEY_BITS-1:0] best_key;
  loc_t               loc;

  assign par_lvl  = lvl_r - LVL_W'(1);
  assign par_row  = pos_r[ROW_W+1:2];
  assign par_half = pos_r[1];
  assign own_row  = pos_r[ROW_W:1];
  assign own_half = pos_r[0];
  assign kid_slot = slot_of(lvl_r + LVL_W'(1), {pos_r[POS_W-2:0], 1'b0});
  assign left_ok  = kid_slot < SLOTX_W'(cnt_r);
  assign right_ok = (kid_slot + SLOTX_W'(1)) < SLOTX_W'(cnt_r);
  assign par_ent  = par_half ? rd_pair.hi : rd_pair.lo;
  assign own_ent  = own_half ? rd_pair.hi : rd_pair.lo;

  // Smaller child against the moving entry; the left child wins a tie.
  assign take_l   = key_less(rd_pair.lo.key, x_r.key);
  assign best_key = take_l ? rd_pair.lo.key : x_r.key;
  assign take_r   = right_ok && key_less(rd_pair.hi.key, best_key);

  // Operation sequencer.
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    x_nxt      = x_r;
    res_nxt    = res_r;
    ext_nxt    = ext_r;
    status_nxt = status_r;
    lvl_nxt    = lvl_r;
    pos_nxt    = pos_r;
    rd_en      = 1'b0;
    rd_lvl     = lvl_r;
    rd_row     = own_row;
    wr_en      = 1'b0;
    wr_lvl     = lvl_r;
    wr_pos     = pos_r;
    wr_ent     = x_r;
    cam_load   = 1'b0;
    loc        = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          status_nxt = ST_OK;
          ext_nxt    = 1'b0;
          case (op_t'(in_opcode))
            OP_INSERT: begin
              if (cnt_r == CNT_W'(CAPACITY)) begin
                status_nxt = ST_FULL;
                state_nxt  = S_DONE;
              end else begin
                loc        = loc_of(cnt_r + CNT_W'(1));
                lvl_nxt    = loc.lvl;
                pos_nxt    = loc.pos;
                x_nxt.key  = in_key;
                x_nxt.vtx  = in_vertex;
                cnt_nxt    = cnt_r + CNT_W'(1);
                state_nxt  = S_UP_RD;
              end
            end
            OP_EXTRACT: begin
              if (cnt_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_DONE;
              end else begin
                res_nxt = top_r;
                ext_nxt = 1'b1;
                cnt_nxt = cnt_r - CNT_W'(1);
                if (cnt_r == CNT_W'(1)) begin
                  state_nxt = S_DONE;
                end else begin
                  loc       = loc_of(cnt_r);
                  lvl_nxt   = loc.lvl;
                  pos_nxt   = loc.pos;
                  state_nxt = S_LAST_RD;
                end
              end
            end
            OP_DECREASE: begin
              x_nxt.key = in_key;
              cam_load  = 1'b1;
              state_nxt = S_SEARCH;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // Wait for the lowest slot holding the vertex.
      S_SEARCH: begin
        if (mres.done) begin
          if (mres.found) begin
            loc       = loc_of(CNT_W'(mres.slot) + CNT_W'(1));
            lvl_nxt   = loc.lvl;
            pos_nxt   = loc.pos;
            state_nxt = S_DEC_RD;
          end else begin
            status_nxt = ST_NOT_FOUND;
            state_nxt  = S_DONE;
          end
        end
      end

      S_DEC_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_DEC_CHK;
      end

      // A new key above the stored one is refused; equal is accepted.
      S_DEC_CHK: begin
        if (key_less(own_ent.key, x_r.key)) begin
          status_nxt = ST_NOT_SMALLER;
          state_nxt  = S_DONE;
        end else begin
          x_nxt.vtx = own_ent.vtx;
          state_nxt = S_UP_RD;
        end
      end

      // Climb: read the parent pair, or settle at the root.
      S_UP_RD: begin
        if (lvl_r == '0) begin
          wr_en     = 1'b1;
          state_nxt = S_DONE;
        end else begin
          rd_en     = 1'b1;
          rd_lvl    = par_lvl;
          rd_row    = par_row;
          state_nxt = S_UP_CHK;
        end
      end

      // Move the parent down into the hole, or drop the entry here.
      S_UP_CHK: begin
        wr_en = 1'b1;
        if (key_less(x_r.key, par_ent.key)) begin
          wr_ent    = par_ent;
          lvl_nxt   = par_lvl;
          pos_nxt   = {1'b0, pos_r[POS_W-1:1]};
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end

      // Fetch the last entry, which refills the root.
      S_LAST_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_LAST_CHK;
      end

      S_LAST_CHK: begin
        x_nxt     = own_ent;
        lvl_nxt   = '0;
        pos_nxt   = '0;
        state_nxt = S_DOWN_RD;
      end

      // Descend: read the child pair, or settle at a leaf.
      S_DOWN_RD: begin
        if (!left_ok) begin
          wr_en     = 1'b1;
          state_nxt = S_DONE;
        end else begin
          rd_en     = 1'b1;
          rd_lvl    = lvl_r + LVL_W'(1);
          rd_row    = pos_r[ROW_W-1:0];
          state_nxt = S_DOWN_CHK;
        end
      end

      // Lift the smaller child into the hole, or drop the entry here.
      S_DOWN_CHK: begin
        wr_en = 1'b1;
        if (take_r) begin
          wr_ent    = rd_pair.hi;
          lvl_nxt   = lvl_r + LVL_W'(1);
          pos_nxt   = {pos_r[POS_W-2:0], 1'b1};
          state_nxt = S_DOWN_RD;
        end else if (take_l) begin
          wr_ent    = rd_pair.lo;
          lvl_nxt   = lvl_r + LVL_W'(1);
          pos_nxt   = {pos_r[POS_W-2:0], 1'b0};
          state_nxt = S_DOWN_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and payload registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ext_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ext_r   <= ext_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r      <= x_nxt;
    res_r    <= res_nxt;
    status_r <= status_nxt;
    lvl_r    <= lvl_nxt;
    pos_r    <= pos_nxt;
    if (wr_en && (wr_lvl == '0)) begin
      top_r <= wr_ent;
    end
  end

  // Request broadcast and level selects.
  assign creq.rd_row = rd_row;
  assign creq.wr_row = wr_pos[ROW_W:1];
  assign creq.wr_lo  = !wr_pos[0];
  assign creq.wr_hi  = wr_pos[0];
  assign creq.wr_ent = wr_ent;

  assign chain[0] = '0;
  assign rd_pair  = chain[NLEV];

  for (genvar g = 0; g < NLEV; g++) begin : g_level
    assign sel_rd[g] = rd_en && (rd_lvl == LVL_W'(g));
    assign sel_wr[g] = wr_en && (wr_lvl == LVL_W'(g));

    mhpq_level_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .sel_rd    (sel_rd[g]),
      .sel_wr    (sel_wr[g]),
      .req       (creq),
      .chain_in  (chain[g]),
      .chain_out (chain[g+1])
    );
  end

  // Vertex tags track every slot write.
  assign wr_slot  = slot_of(wr_lvl, wr_pos);
  assign mwr.en   = wr_en;
  assign mwr.slot = wr_slot[SLOT_W-1:0];
  assign mwr.vtx  = wr_ent.vtx;

  mhpq_vertex_match u_match (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (cam_load),
    .tgt   (in_vertex),
    .cnt   (cnt_r),
    .wr    (mwr),
    .res   (mres)
  );

  // Result ports.
  assign busy            = (state_r != S_IDLE);
  assign out_valid       = (state_r == S_DONE);
  assign out_status      = status_r;
  assign out_entry_count = cnt_r;

  always_comb begin
    if (ext_r) begin
      out_min_vertex = res_r.vtx;
      out_min_key    = res_r.key;
    end else if (cnt_r != '0) begin
      out_min_vertex = top_r.vtx;
      out_min_key    = top_r.key;
    end else begin
      out_min_vertex = '0;
      out_min_key    = '0;
    end
  end

  // Checks on the sequencer.
  `MHPQ_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe longer than one cycle")
  `MHPQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
  `MHPQ_ASSERT_NEXT(a_count_hold, busy, $stable(cnt_r), "entry count moved during an operation")
  `MHPQ_ASSERT_SAME(a_count_range, 1'b1, cnt_r <= CNT_W'(CAPACITY), "entry count above capacity")
  `MHPQ_ASSERT_SAME(a_one_read, 1'b1, $onehot0(sel_rd), "more than one level read at once")

endmodule

`default_nettype wire

/* sv/mhpq_level_cell.sv */
// ----------------------------------------------------------------------------
// mhpq_level_cell
// One level of the heap tree: a sibling-pair memory with a registered read
// port, and a link in the read data chain that runs through all levels.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_level_cell import mhpq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      sel_rd,
  input  logic      sel_wr,
  input  cell_req_t req,
  input  pair_t     chain_in,
  output pair_t     chain_out
);

  entry_t mem_lo [ROWS];
  entry_t mem_hi [ROWS];
  entry_t rd_lo_r;
  entry_t rd_hi_r;
  logic   hit_r;

  // Write either half of a row.
  always_ff @(posedge clk) begin
    if (sel_wr && req.wr_lo) begin
      mem_lo[req.wr_row] <= req.wr_ent;
    end
    if (sel_wr && req.wr_hi) begin
      mem_hi[req.wr_row] <= req.wr_ent;
    end
  end

  // Registered read of a whole sibling pair.
  always_ff @(posedge clk) begin
    if (sel_rd) begin
      rd_lo_r <= mem_lo[req.rd_row];
      rd_hi_r <= mem_hi[req.rd_row];
    end
  end

  // Remember whether this level owns the data on the chain this cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= sel_rd;
    end
  end

  // Put our read data on the chain, or pass the upstream data along.
  always_comb begin
    if (hit_r) begin
      chain_out.hi = rd_hi_r;
      chain_out.lo = rd_lo_r;
    end else begin
      chain_out = chain_in;
    end
  end

endmodule

`default_nettype wire

/* sv/mhpq_vertex_match.sv */
// ----------------------------------------------------------------------------
// mhpq_vertex_match
// Vertex tags of all heap slots with a parallel compare; the lowest matching
// slot below the entry count is found by scanning one chunk per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_vertex_match import mhpq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  logic [VTX_W-1:0] tgt,
  input  logic [CNT_W-1:0] cnt,
  input  match_wr_t        wr,
  output match_res_t       res
);

  logic [VTX_W-1:0]    vtx_r [CAPACITY];
  logic [CAPACITY-1:0] match_now;
  logic [CAPACITY-1:0] mvec_r;
  logic [CIDX_W-1:0]   chunk_r;
  logic                scan_r;
  logic [CHUNK-1:0]    bits;
  logic [CHUNK_W-1:0]  enc;
  logic                any;
  logic                last;

  // Tag update follows every heap slot write.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      vtx_r[wr.slot] <= wr.vtx;
    end
  end

  // Compare every live slot against the requested vertex.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match_now[i] = (vtx_r[i] == tgt) && (CNT_W'(i) < cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mvec_r <= match_now;
    end
  end

  // Lowest set bit of the current chunk.
  always_comb begin
    bits = mvec_r[{chunk_r, {CHUNK_W{1'b0}}} +: CHUNK];
    enc  = '0;
    for (int i = CHUNK - 1; i >= 0; i--) begin
      if (bits[i]) begin
        enc = CHUNK_W'(i);
      end
    end
    any  = |bits;
    last = (chunk_r == {CIDX_W{1'b1}});
  end

  assign res.done  = scan_r && (any || last);
  assign res.found = any;
  assign res.slot  = {chunk_r, enc};

  // Scan sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r  <= 1'b0;
      chunk_r <= '0;
    end else if (load) begin
      scan_r  <= 1'b1;
      chunk_r <= '0;
    end else if (scan_r) begin
      if (any || last) begin
        scan_r <= 1'b0;
      end else begin
        chunk_r <= chunk_r + CIDX_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* verif/mhpq_checker.sv */
// ----------------------------------------------------------------------------
// Min-heap priority queue checker
// Watches the request and result channels of the heap unit, keeps its own
// copy of the heap, predicts one result per accepted request and compares
// every result field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package mhpq_tb_pkg;

  // Request opcodes; the last one leaves the heap alone.
  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_EXTRACT  = 2'd1,
    OP_DECREASE = 2'd2,
    OP_NOP      = 2'd3
  } heap_op_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_EMPTY       = 3'd1,
    ST_FULL        = 3'd2,
    ST_NOT_SMALLER = 3'd3,
    ST_NOT_FOUND   = 3'd4
  } heap_status_e;

endpackage

module mhpq_checker import mhpq_pkg::*; import mhpq_tb_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic [1:0]                 in_opcode,
  input  logic signed [KEY_BITS-1:0] in_key,
  input  logic [VTX_W-1:0]           in_vertex,
  input  logic                       out_valid,
  input  logic [2:0]                 out_status,
  input  logic [VTX_W-1:0]           out_min_vertex,
  input  logic signed [KEY_BITS-1:0] out_min_key,
  input  logic [CNT_W-1:0]           out_entry_count,
  output int                         fail_count,
  output int                         pending
);

  typedef struct packed {
    heap_status_e               status;
    logic [VTX_W-1:0]           vtx;
    logic signed [KEY_BITS-1:0] key;
    logic [CNT_W-1:0]           count;
  } heap_result_t;

  // Shadow heap: zero-based, children of slot i at 2i+1 and 2i+2.
  logic signed [KEY_BITS-1:0] heap_key [CAPACITY];
  logic [VTX_W-1:0]           heap_vtx [CAPACITY];
  int                         heap_size;

  heap_result_t expected_q [$];
  int           result_num;

  initial begin
    fail_count = 0;
    pending    = 0;
    heap_size  = 0;
    result_num = 0;
  end

  function automatic void swap_slots(int a, int b);
    logic signed [KEY_BITS-1:0] k;
    logic [VTX_W-1:0]           v;
    k           = heap_key[a];
    v           = heap_vtx[a];
    heap_key[a] = heap_key[b];
    heap_vtx[a] = heap_vtx[b];
    heap_key[b] = k;
    heap_vtx[b] = v;
  endfunction

  // Climb while strictly smaller than the parent; equal keys stay put.
  function automatic void bubble_up(int i);
    int p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!(heap_key[i] < heap_key[p])) break;
      swap_slots(i, p);
      i = p;
    end
  endfunction

  // Descend toward the smaller child; the left child wins a tie.
  function automatic void bubble_down(int i);
    int l;
    int r;
    int m;
    while (1) begin
      l = 2 * i + 1;
      r = l + 1;
      m = i;
      if (l < heap_size && heap_key[l] < heap_key[m]) m = l;
      if (r < heap_size && heap_key[r] < heap_key[m]) m = r;
      if (m == i) break;
      swap_slots(i, m);
      i = m;
    end
  endfunction

  // Apply one request to the shadow heap and return the result it yields.
  function automatic heap_result_t apply_request(heap_op_e op,
                                                 logic signed [KEY_BITS-1:0] key,
                                                 logic [VTX_W-1:0] vtx);
    heap_result_t res;
    logic         extracted;
    int           slot;
    res       = '0;
    res.status = ST_OK;
    extracted = 1'b0;
    slot      = -1;
    case (op)
      OP_INSERT: begin
        if (heap_size >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          heap_key[heap_size] = key;
          heap_vtx[heap_size] = vtx;
          heap_size++;
          bubble_up(heap_size - 1);
        end
      end
      OP_EXTRACT: begin
        if (heap_size == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.vtx   = heap_vtx[0];
          res.key   = heap_key[0];
          extracted = 1'b1;
          heap_size--;
          heap_key[0] = heap_key[heap_size];
          heap_vtx[0] = heap_vtx[heap_size];
          bubble_down(0);
        end
      end
      OP_DECREASE: begin
        // The lowest slot holding the vertex is the one that changes.
        for (int i = heap_size - 1; i >= 0; i--) begin
          if (heap_vtx[i] == vtx) slot = i;
        end
        if (slot < 0) begin
          res.status = ST_NOT_FOUND;
        end else if (heap_key[slot] < key) begin
          res.status = ST_NOT_SMALLER;
        end else begin
          heap_key[slot] = key;
          bubble_up(slot);
        end
      end
      default: begin
      end
    endcase
    // Report the top unless an extract already filled the pair in.
    if (!extracted && heap_size > 0) begin
      res.vtx = heap_vtx[0];
      res.key = heap_key[0];
    end
    res.count = CNT_W'(heap_size);
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    fail_count++;
    $display("%0t mhpq_checker: %s", $realtime, msg);
  endtask

  task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s is %0h, predicted %0h",
                                result_num, name, got, want));
    end
  endtask

  // Results are checked before the request of the same edge is predicted;
  // the busy handshake keeps the two from belonging to one request.
  always @(posedge clk) begin
    heap_result_t want;
    if (!rst_n) begin
      heap_size = 0;
      expected_q.delete();
    end else begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no request waiting",
                                    result_num));
        end else begin
          want = expected_q.pop_front();
          compare_field("status", 64'(out_status), 64'(want.status));
          compare_field("min_vertex", 64'(out_min_vertex), 64'(want.vtx));
          compare_field("min_key", 64'(out_min_key), 64'(want.key));
          compare_field("entry_count", 64'(out_entry_count), 64'(want.count));
        end
        result_num++;
      end
      if (start && !busy) begin
        expected_q.push_back(apply_request(heap_op_e'(in_opcode), in_key, in_vertex));
      end
    end
    pending <= expected_q.size();
  end

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// Min-heap priority queue testbench
// Drives insert, extract-minimum, decrease-key and no-op requests into the
// heap unit in random bursts: a directed opening on the edge cases, a mixed
// random phase, a fill to capacity and full drain, and a closing mix. The
// checker beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import mhpq_pkg::*;
  import mhpq_tb_pkg::*;

  localparam int RUN_LIMIT    = 500000;
  localparam int DRAIN_CYCLES = 100;
  localparam logic signed [KEY_BITS-1:0] KEY_MAX = {1'b0, {(KEY_BITS-1){1'b1}}};
  localparam logic signed [KEY_BITS-1:0] KEY_MIN = {1'b1, {(KEY_BITS-1){1'b0}}};

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic [1:0]                 in_opcode;
  logic signed [KEY_BITS-1:0] in_key;
  logic [VTX_W-1:0]           in_vertex;
  logic                       out_valid;
  logic [2:0]                 out_status;
  logic [VTX_W-1:0]           out_min_vertex;
  logic signed [KEY_BITS-1:0] out_min_key;
  logic [CNT_W-1:0]           out_entry_count;
  int                         fail_count;
  int                         pending;
  int unsigned                cycle_count = 0;
  int                         burst_left = 0;

  // Rough memory of keys handed out per vertex, used to aim decrease requests.
  logic signed [KEY_BITS-1:0] last_key [256];
  logic [VTX_W-1:0]           live_vtx [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  min_heap_priority_queue_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_key         (in_key),
    .in_vertex      (in_vertex),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_min_vertex (out_min_vertex),
    .out_min_key    (out_min_key),
    .out_entry_count(out_entry_count)
  );

  mhpq_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_key         (in_key),
    .in_vertex      (in_vertex),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_min_vertex (out_min_vertex),
    .out_min_key    (out_min_key),
    .out_entry_count(out_entry_count),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Present one request at the falling edge and hold it until accepted.
  task automatic issue(heap_op_e op, logic signed [KEY_BITS-1:0] key,
                       logic [VTX_W-1:0] vtx);
    start     <= 1'b1;
    in_opcode <= op;
    in_key    <= key;
    in_vertex <= vtx;
    if (op == OP_INSERT) begin
      last_key[vtx] = key;
      live_vtx.push_back(vtx);
      if (live_vtx.size() > 64) void'(live_vtx.pop_front());
    end else if (op == OP_DECREASE && key < last_key[vtx]) begin
      last_key[vtx] = key;
    end
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Bursts of random length, sometimes long, with random gaps between them.
  task automatic pace_sender();
    if (burst_left == 0) begin
      pause($urandom_range(1, 12));
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 10);
    end
    burst_left--;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Keys: mostly a narrow band for ties, plus full range and extremes.
  function automatic logic signed [KEY_BITS-1:0] rand_key();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return KEY_BITS'($signed($urandom_range(0, 200)) - 100);
    if (r < 8) return KEY_BITS'($urandom);
    case ($urandom_range(0, 3))
      0:       return KEY_MAX;
      1:       return KEY_MIN;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // Vertices: a small set for duplicates and hits, sometimes any value.
  function automatic logic [VTX_W-1:0] rand_vertex();
    if ($urandom_range(0, 9) < 7) return VTX_W'($urandom_range(0, 31));
    return VTX_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [VTX_W-1:0] pick_vertex();
    if (live_vtx.size() > 0 && $urandom_range(0, 9) < 8) begin
      return live_vtx[$urandom_range(0, live_vtx.size() - 1)];
    end
    return rand_vertex();
  endfunction

  // Mostly a smaller key, sometimes equal, larger or arbitrary.
  function automatic logic signed [KEY_BITS-1:0] decrease_key(logic [VTX_W-1:0] vtx);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return last_key[vtx] - KEY_BITS'($urandom_range(0, 1000));
    if (r == 6) return last_key[vtx];
    if (r == 7) return last_key[vtx] + KEY_BITS'($urandom_range(1, 1000));
    return rand_key();
  endfunction

  // One paced random request; weights are percentages, the rest are no-ops.
  task automatic random_request(int ins_w, int ext_w, int dec_w);
    int unsigned      r;
    logic [VTX_W-1:0] v;
    r = $urandom_range(0, 99);
    pace_sender();
    if (r < ins_w) begin
      issue(OP_INSERT, rand_key(), rand_vertex());
    end else if (r < ins_w + ext_w) begin
      issue(OP_EXTRACT, KEY_BITS'($urandom), VTX_W'($urandom));
    end else if (r < ins_w + ext_w + dec_w) begin
      v = pick_vertex();
      issue(OP_DECREASE, decrease_key(v), v);
    end else begin
      issue(OP_NOP, KEY_BITS'($urandom), VTX_W'($urandom));
    end
  endtask

  initial begin
    start     = 1'b0;
    in_opcode = OP_NOP;
    in_key    = '0;
    in_vertex = '0;
    rst_n     = 1'b0;
    for (int i = 0; i < 256; i++) last_key[i] = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty heap errors, key extremes, duplicates, ties, and
    // decrease requests that are equal, smaller, larger and absent.
    issue(OP_EXTRACT, '0, '0);
    issue(OP_DECREASE, '0, 8'd5);
    issue(OP_NOP, '1, '1);
    issue(OP_INSERT, KEY_MAX, 8'd255);
    issue(OP_INSERT, KEY_MIN, 8'd0);
    issue(OP_INSERT, '0, 8'd1);
    issue(OP_INSERT, '1, 8'd1);
    issue(OP_INSERT, '0, 8'd2);
    issue(OP_DECREASE, 32'sd5, 8'd1);
    issue(OP_DECREASE, KEY_MAX, 8'd255);
    issue(OP_DECREASE, -32'sd5, 8'd255);
    issue(OP_DECREASE, '0, 8'd77);
    issue(OP_DECREASE, KEY_MIN, 8'd2);
    issue(OP_NOP, '0, '0);
    repeat (7) issue(OP_EXTRACT, '0, '0);

    // Let every result come back before the random part starts.
    wait_drained();

    // Mixed random traffic.
    repeat (300) random_request(45, 25, 25);

    // Fill past capacity, poke the full heap, then drain past empty.
    repeat (262) begin
      pace_sender();
      issue(OP_INSERT, rand_key(), rand_vertex());
    end
    repeat (10) random_request(0, 0, 100);
    repeat (2) random_request(0, 0, 0);
    repeat (262) begin
      pace_sender();
      issue(OP_EXTRACT, KEY_BITS'($urandom), VTX_W'($urandom));
    end
    live_vtx.delete();

    // Closing mix, heavier on extraction.
    repeat (150) random_request(30, 35, 30);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
